@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each one samples on the rising edge
// of clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge.
`define APGP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence holds in the same cycle as the trigger.
`define APGP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence holds in the cycle after the trigger.
`define APGP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/apgp_pkg.sv @@
`default_nettype none

package apgp_pkg;

   // Ring geometry
   localparam int BUF_DEPTH = 1024;
   localparam int AddrW     = $clog2(BUF_DEPTH);
   localparam int CntW      = $clog2(BUF_DEPTH + 1);

   // Field and register widths
   localparam int SampleW   = 16;
   localparam int GainW     = 16;
   localparam int GainFracW = 8;
   localparam int QuietW    = 15;
   localparam int PrimeW    = 11;
   localparam int DutyW     = 8;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 16;
   localparam int CmdW      = 2;

   localparam int ProdW     = SampleW + GainW;
   localparam int XW        = ProdW - GainFracW;
   localparam int CmpW      = (CntW > PrimeW) ? CntW : PrimeW;
   localparam int MulCntW   = $clog2(GainW + 1);

   localparam logic [GainW-1:0]          GAIN_RESET = 16'd256;
   localparam logic signed [SampleW-1:0] SAT_MAX    = 16'sh7FFF;
   localparam logic signed [SampleW-1:0] SAT_MIN    = 16'sh8000;
   localparam logic signed [ProdW-1:0]   ROUND_BIAS = 32'sd255;

   typedef enum logic [CmdW-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_VOLUME_GAIN = 2'd0,
      CSR_QUIET_LEVEL = 2'd1,
      CSR_PRIME_DELAY = 2'd2,
      CSR_DIRECT_MODE = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } ring_ctl_type;

endpackage

`default_nettype wire

@@ design/apgp_if.sv @@
`default_nettype none

interface apgp_req_if import apgp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CmdW-1:0]           command;
   logic signed [SampleW-1:0] sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink   (input valid, input command, input sample, output ready);
endinterface

interface apgp_rsp_if import apgp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DutyW-1:0] duty_main;
   logic [DutyW-1:0] duty_comp;
   logic             played;
   logic             overflow;

   modport source (output valid, output duty_main, output duty_comp, output played,
                   output overflow, input ready);
   modport sink   (input valid, input duty_main, input duty_comp, input played,
                   input overflow, output ready);
endinterface

`default_nettype wire

@@ design/apgp_ring.sv @@
`default_nettype none

module apgp_ring import apgp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ring_ctl_type              ctl,
   input  logic signed [SampleW-1:0] wdata,
   output logic signed [SampleW-1:0] rdata,
   output logic [CntW-1:0]           count
);

   logic signed [SampleW-1:0] mem [BUF_DEPTH];
   logic signed [SampleW-1:0] rdata_ff;
   logic [AddrW-1:0]          rd_idx_ff, rd_idx_in;
   logic [AddrW-1:0]          wr_idx_ff, wr_idx_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;

   function automatic logic [AddrW-1:0] next_pos(input logic [AddrW-1:0] p);
      return (p == AddrW'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      cnt_in    = cnt_ff;
      if (ctl.clear) begin
         rd_idx_in = '0;
         wr_idx_in = '0;
         cnt_in    = '0;
      end else if (ctl.push) begin
         wr_idx_in = next_pos(wr_idx_ff);
         cnt_in    = cnt_ff + 1'b1;
      end else if (ctl.pop) begin
         rd_idx_in = next_pos(rd_idx_ff);
         cnt_in    = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_idx_ff] <= wdata;
      end
      if (ctl.pop) begin
         rdata_ff <= mem[rd_idx_ff];
      end
   end

   assign rdata = rdata_ff;
   assign count = cnt_ff;

endmodule

`default_nettype wire

@@ design/apgp_mul.sv @@
`default_nettype none

module apgp_mul import apgp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SampleW-1:0] mcand,
   input  logic [GainW-1:0]          mplier,
   output logic                      done,
   output logic signed [ProdW-1:0]   product
);

   logic signed [ProdW-1:0] acc_ff, acc_in;
   logic signed [ProdW-1:0] msh_ff, msh_in;
   logic [GainW-1:0]        gsh_ff, gsh_in;
   logic [MulCntW-1:0]      cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   // One multiplier bit per cycle: add the shifted sample where the bit is set
   always_comb begin
      acc_in  = acc_ff;
      msh_in  = msh_ff;
      gsh_in  = gsh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         msh_in  = ProdW'(mcand);
         gsh_in  = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (gsh_ff[0]) begin
            acc_in = acc_ff + msh_ff;
         end
         msh_in = msh_ff <<< 1;
         gsh_in = gsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MulCntW'(GainW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      msh_ff <= msh_in;
      gsh_ff <= gsh_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

@@ design/audio_playout_gain_pwm.sv @@
// Audio playout buffer with Q8.8 gain, quiet-band squelch and PWM duty output.
// req_ch (valid/ready) carries one command per transaction: push stores a
// sample in the 1024-entry ring (or flags overflow when full), tick pops the
// oldest sample once the priming delay is passed (or whenever non-empty in
// direct mode) and turns it into an offset-binary duty pair, clear empties
// the ring. Every request transaction yields exactly one transaction on rsp_ch.
// The csr_ port writes volume_gain, quiet_level, prime_delay and direct_mode;
// write it only while the block is idle.
// Sequence: push, clear and the unused code go from acceptance straight to the
// output step; a tick passes through the read, multiply, shape and output
// steps, the shift-add multiplier retiring one gain bit per cycle. The block
// is not ready while it works on an item, so it takes no new request until
// that item's result is loaded into the output register.
// A finished response sits in an output register; the next request is taken
// while it waits. When the receiver stalls, the following result is held
// inside until the output register frees up.
// Reset (synchronous, active high) empties the ring and restores the register
// defaults (unity gain, no squelch, no priming, normal mode); ring contents
// are left as they are.
`default_nettype none
`include "assert_macros.svh"

module audio_playout_gain_pwm import apgp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   apgp_req_if.sink            req_ch,
   apgp_rsp_if.source          rsp_ch,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_MUL   = 5'b00100,
      S_SHAPE = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [GainW-1:0]  gain_ff;
   logic [QuietW-1:0] quiet_ff;
   logic [PrimeW-1:0] prime_ff;
   logic              direct_ff;

   // Pending result, filled by the sequencer
   logic [DutyW-1:0] res_duty_ff, res_duty_in;
   logic [DutyW-1:0] res_comp_ff, res_comp_in;
   logic             res_played_ff, res_played_in;
   logic             res_ovf_ff, res_ovf_in;
   logic signed [XW-1:0] x_ff, x_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DutyW-1:0] rsp_duty_ff, rsp_comp_ff;
   logic             rsp_played_ff, rsp_ovf_ff;
   logic             rsp_load;

   ring_ctl_type              ring_ctl;
   logic signed [SampleW-1:0] ring_rdata;
   logic [CntW-1:0]           ring_count;
   logic                      ring_full;
   logic                      pop_ok;
   logic                      req_acc;

   logic                      mul_start;
   logic                      mul_done;
   logic signed [SampleW-1:0] mul_mcand;
   logic signed [ProdW-1:0]   mul_prod;
   logic signed [ProdW-1:0]   prod_biased;

   logic signed [SampleW-1:0] sat_x;
   logic signed [SampleW:0]   wide_x;
   logic signed [SampleW:0]   quiet_pos;
   logic signed [SampleW-1:0] shaped_x;
   logic [DutyW-1:0]          duty_u;

   apgp_ring u_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (ring_ctl),
      .wdata (req_ch.sample),
      .rdata (ring_rdata),
      .count (ring_count)
   );

   // Silence enters the multiplier as a zero sample
   assign mul_mcand = res_played_ff ? ring_rdata : '0;

   apgp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (gain_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign ring_full    = (ring_count == CntW'(BUF_DEPTH));
   assign pop_ok       = (direct_ff && (ring_count != '0)) ||
                         (CmpW'(ring_count) > CmpW'(prime_ff));

   // Divide by 256 toward zero: bias negative products before the shift
   assign prod_biased = mul_prod + (mul_prod[ProdW-1] ? ROUND_BIAS : '0);

   // Saturate, squelch the quiet band, convert to offset binary top byte
   always_comb begin
      if (x_ff > XW'(SAT_MAX)) begin
         sat_x = SAT_MAX;
      end else if (x_ff < XW'(SAT_MIN)) begin
         sat_x = SAT_MIN;
      end else begin
         sat_x = x_ff[SampleW-1:0];
      end
      wide_x    = (SampleW + 1)'(sat_x);
      quiet_pos = $signed({2'b00, quiet_ff});
      if ((wide_x < quiet_pos) && (wide_x > -quiet_pos)) begin
         shaped_x = '0;
      end else begin
         shaped_x = sat_x;
      end
      duty_u = {~shaped_x[SampleW-1], shaped_x[SampleW-2:SampleW-DutyW]};
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ring_ctl      = '0;
      mul_start     = 1'b0;
      rsp_load      = 1'b0;
      res_duty_in   = res_duty_ff;
      res_comp_in   = res_comp_ff;
      res_played_in = res_played_ff;
      res_ovf_in    = res_ovf_ff;
      x_in          = x_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               res_duty_in   = '0;
               res_comp_in   = '0;
               res_played_in = 1'b0;
               res_ovf_in    = 1'b0;
               state_in      = S_OUT;
               case (req_ch.command)
                  CMD_PUSH: begin
                     if (ring_full) begin
                        res_ovf_in = 1'b1;
                     end else begin
                        ring_ctl.push = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     // Pop now; the read data lands in the ring's output register
                     ring_ctl.pop  = pop_ok;
                     res_played_in = pop_ok;
                     state_in      = S_READ;
                  end
                  CMD_CLEAR: begin
                     ring_ctl.clear = 1'b1;
                  end
                  default: begin
                     // unused code: no state change, all-zero response
                  end
               endcase
            end
         end
         S_READ: begin
            mul_start = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            if (mul_done) begin
               x_in     = prod_biased[ProdW-1:GainFracW];
               state_in = S_SHAPE;
            end
         end
         S_SHAPE: begin
            res_duty_in = duty_u;
            res_comp_in = DutyW'(0) - duty_u;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // Hold here while the previous response is still unclaimed
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_duty_ff   <= res_duty_in;
      res_comp_ff   <= res_comp_in;
      res_played_ff <= res_played_in;
      res_ovf_ff    <= res_ovf_in;
      x_ff          <= x_in;
      if (rsp_load) begin
         rsp_duty_ff   <= res_duty_ff;
         rsp_comp_ff   <= res_comp_ff;
         rsp_played_ff <= res_played_ff;
         rsp_ovf_ff    <= res_ovf_ff;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         quiet_ff  <= '0;
         prime_ff  <= '0;
         direct_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VOLUME_GAIN: gain_ff   <= csr_wdata[GainW-1:0];
            CSR_QUIET_LEVEL: quiet_ff  <= csr_wdata[QuietW-1:0];
            CSR_PRIME_DELAY: prime_ff  <= csr_wdata[PrimeW-1:0];
            CSR_DIRECT_MODE: direct_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.duty_main = rsp_duty_ff;
   assign rsp_ch.duty_comp = rsp_comp_ff;
   assign rsp_ch.played    = rsp_played_ff;
   assign rsp_ch.overflow  = rsp_ovf_ff;

   `APGP_ASSERT_ALWAYS(a_fill_bound, ring_count <= CntW'(BUF_DEPTH), "ring fill count beyond depth")
   `APGP_ASSERT_NEXT(a_drop_flag, req_acc && (req_ch.command == CMD_PUSH) && ring_full, res_ovf_ff && (state_ff == S_OUT), "dropped push not flagged")
   `APGP_ASSERT_IMPLY(a_mul_done, mul_done, state_ff == S_MUL, "multiplier finished outside its step")

endmodule

`default_nettype wire
